>>> rtl/load_cell_adc_reader_with_tare_macros.svh
// Assertion macros shared by the load-cell reader RTL.
`ifndef LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH
`define LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LCAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcar assertion failed");

// Next-cycle implication, held off during reset.
`define LCAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcar assertion failed");

`endif

>>> rtl/lcar_pkg.sv
// Shared constants, types and codes for the load-cell reader.
package lcar_pkg;

    localparam int DATA_BITS   = 24;
    localparam int TARE_READS  = 5;
    localparam int RAW_W       = 24;
    localparam int READING_W   = 16;
    localparam int NUM_DIGITS  = 5;
    localparam int DIGIT_W     = 4;
    localparam int INTERVAL_W  = 24;
    localparam int HALF_W      = 8;
    localparam int PULSE_W     = 5;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int SHIFT_W     = DATA_BITS;
    localparam int READS_W     = $clog2(TARE_READS + 1);
    localparam int TARE_SUM_W  = READING_W + $clog2(TARE_READS);
    localparam int MIN_PULSES  = DATA_BITS + 1;

    // tare = sum / TARE_READS as a reciprocal multiply; exact for sums below 2^22
    localparam int TARE_SHIFT   = 22;
    localparam int TARE_RECIP   = (2**TARE_SHIFT + TARE_READS - 1) / TARE_READS;
    localparam int TARE_RECIP_W = TARE_SHIFT + 1;
    localparam int TARE_PROD_W  = TARE_SUM_W + TARE_RECIP_W;

    // v / 10 for 16-bit v as (v * 52429) >> 19
    localparam int DIV10_RECIP  = 52429;
    localparam int DIV10_SHIFT  = 19;
    localparam int DIV10_PROD_W = DIV10_SHIFT + READING_W;

    // queue depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = INTERVAL_W'(1000000);
    localparam logic [HALF_W-1:0]     HALF_PERIOD_RST     = HALF_W'(10);
    localparam logic [PULSE_W-1:0]    GAIN_PULSES_RST     = PULSE_W'(25);

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INTERVAL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PULSES     = CFG_INDEX_W'(2);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_IDLE
    } lcar_phase_t;

    typedef logic [DIGIT_W-1:0] lcar_digit_t;

    typedef struct packed {
        logic                 sck_level;
        logic                 tare_done;
        logic                 net_valid;
        logic [READING_W-1:0] net_value;
    } lcar_rec_t;

endpackage

>>> rtl/lcar_if.sv
// Channel interfaces: converter ticks in, per-tick results out.
interface lcar_tick_if;
    logic valid;
    logic ready;
    logic dout_level;

    modport source (output valid, output dout_level, input ready);
    modport sink (input valid, input dout_level, output ready);
endinterface

interface lcar_result_if import lcar_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 sck_level;
    logic                 tare_done;
    logic                 net_valid;
    logic [READING_W-1:0] net_value;
    lcar_digit_t          digit_units;
    lcar_digit_t          digit_tens;
    lcar_digit_t          digit_hundreds;
    lcar_digit_t          digit_thousands;
    lcar_digit_t          digit_tenthousands;

    modport source (
        output valid, output sck_level, output tare_done, output net_valid,
        output net_value, output digit_units, output digit_tens,
        output digit_hundreds, output digit_thousands, output digit_tenthousands,
        input ready
    );
    modport sink (
        input valid, input sck_level, input tare_done, input net_valid,
        input net_value, input digit_units, input digit_tens,
        input digit_hundreds, input digit_thousands, input digit_tenthousands,
        output ready
    );
endinterface

>>> rtl/lcar_fifo.sv
// Short record queue between the tick front end and the digit pipeline.
`include "load_cell_adc_reader_with_tare_macros.svh"

module lcar_fifo import lcar_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  lcar_rec_t push_rec,
    output logic      push_ready,
    input  logic      pop,
    output logic      head_valid,
    output lcar_rec_t head_rec
);

    lcar_rec_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   push;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `LCAR_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, head_valid)
    `LCAR_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + FIFO_CNT_W'(1))
    `LCAR_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - FIFO_CNT_W'(1))

endmodule

>>> rtl/lcar_front.sv
// Tick front end: config registers, serial clock sequencer, tare and net value.
`include "load_cell_adc_reader_with_tare_macros.svh"

module lcar_front import lcar_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    lcar_tick_if.sink              tick,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   push_valid,
    output lcar_rec_t              push_rec,
    input  logic                   push_ready
);

    logic [INTERVAL_W-1:0] sample_interval_reg, sample_interval_next;
    logic [HALF_W-1:0]     half_period_reg, half_period_next;
    logic [PULSE_W-1:0]    gain_pulses_reg, gain_pulses_next;

    lcar_phase_t           phase_reg, phase_next;
    logic [PULSE_W-1:0]    pulse_index_reg, pulse_index_next;
    logic [HALF_W-1:0]     half_counter_reg, half_counter_next;
    logic [SHIFT_W-1:0]    shift_word_reg, shift_word_next;
    logic [INTERVAL_W-1:0] interval_counter_reg, interval_counter_next;
    logic [TARE_SUM_W-1:0] tare_sum_reg, tare_sum_next;
    logic [READS_W-1:0]    tare_reads_done_reg, tare_reads_done_next;
    logic [READING_W-1:0]  tare_value_reg, tare_value_next;
    logic [READING_W-1:0]  net_reg, net_next;

    logic                   accept;
    logic [PULSE_W-1:0]     total_pulses;
    logic                   was_tared;
    logic                   trigger;
    logic                   half_done;
    logic [PULSE_W-1:0]     pulse_inc;
    logic [RAW_W-1:0]       raw_word;
    logic [RAW_W-1:0]       neg_word;
    logic [READING_W-1:0]   reading;
    logic                   net_valid_now;
    logic [TARE_PROD_W-1:0] tare_prod;

    assign tick.ready = push_ready;
    assign accept     = tick.valid && push_ready;

    // ---- configuration registers ----
    always_comb
    begin
        sample_interval_next = sample_interval_reg;
        half_period_next     = half_period_reg;
        gain_pulses_next     = gain_pulses_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_INTERVAL: sample_interval_next = cfg_data[INTERVAL_W-1:0];
                CFG_HALF_PERIOD:     half_period_next     = cfg_data[HALF_W-1:0];
                CFG_GAIN_PULSES:     gain_pulses_next     = cfg_data[PULSE_W-1:0];
                default:             ;
            endcase
        end
    end

    // ---- derived values ----
    assign total_pulses = (gain_pulses_reg < PULSE_W'(MIN_PULSES)) ? PULSE_W'(MIN_PULSES)
                                                                     : gain_pulses_reg;
    assign was_tared    = (tare_reads_done_reg == READS_W'(TARE_READS));
    // a zero period compares the same as one
    assign half_done    = ({1'b0, half_counter_reg} + (HALF_W + 1)'(1))
                          >= {1'b0, half_period_reg};
    assign pulse_inc    = pulse_index_reg + PULSE_W'(1);
    assign raw_word     = RAW_W'(shift_word_reg) << (RAW_W - DATA_BITS);
    assign neg_word     = RAW_W'(0) - raw_word;
    assign reading      = neg_word[RAW_W-1 -: READING_W];

    // tare divide; the sum is frozen long before the next use of the tare
    assign tare_prod       = TARE_PROD_W'(tare_sum_reg) * TARE_PROD_W'(TARE_RECIP);
    assign tare_value_next = tare_prod[TARE_SHIFT +: READING_W];

    // ---- next state ----
    always_comb
    begin
        phase_next            = phase_reg;
        pulse_index_next      = pulse_index_reg;
        half_counter_next     = half_counter_reg;
        shift_word_next       = shift_word_reg;
        interval_counter_next = interval_counter_reg;
        tare_sum_next         = tare_sum_reg;
        tare_reads_done_next  = tare_reads_done_reg;
        net_next              = net_reg;
        net_valid_now         = 1'b0;
        trigger               = 1'b0;

        // free-running interval timer once tared
        if (was_tared)
        begin
            if (({1'b0, interval_counter_reg} + (INTERVAL_W + 1)'(1))
                >= {1'b0, sample_interval_reg})
            begin
                interval_counter_next = '0;
                trigger               = 1'b1;
            end
            else
            begin
                interval_counter_next = interval_counter_reg + INTERVAL_W'(1);
            end
        end

        unique case (phase_reg)
            PH_WAIT:
            begin
                if (!tick.dout_level)
                begin
                    phase_next        = PH_HIGH;
                    pulse_index_next  = '0;
                    half_counter_next = '0;
                    shift_word_next   = '0;
                end
            end
            PH_HIGH:
            begin
                if (half_done)
                begin
                    half_counter_next = '0;
                    phase_next        = PH_LOW;
                end
                else
                begin
                    half_counter_next = half_counter_reg + HALF_W'(1);
                end
            end
            PH_LOW:
            begin
                // sample on the first low tick of a data pulse
                if (half_counter_reg == '0 && pulse_index_reg < PULSE_W'(DATA_BITS))
                begin
                    shift_word_next = {shift_word_reg[SHIFT_W-2:0], tick.dout_level};
                end
                if (half_done)
                begin
                    half_counter_next = '0;
                    if (pulse_inc >= total_pulses)
                    begin
                        pulse_index_next = '0;
                        if (!was_tared)
                        begin
                            tare_sum_next        = tare_sum_reg + TARE_SUM_W'(reading);
                            tare_reads_done_next = tare_reads_done_reg + READS_W'(1);
                            if (tare_reads_done_next == READS_W'(TARE_READS))
                            begin
                                phase_next            = PH_IDLE;
                                interval_counter_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                        else
                        begin
                            net_next      = reading - tare_value_reg;
                            net_valid_now = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    else
                    begin
                        pulse_index_next = pulse_inc;
                        phase_next       = PH_HIGH;
                    end
                end
                else
                begin
                    half_counter_next = half_counter_reg + HALF_W'(1);
                end
            end
            PH_IDLE:
            begin
                if (trigger)
                begin
                    phase_next = PH_WAIT;
                end
            end
        endcase
    end

    // ---- outputs ----
    always_comb
    begin
        push_valid         = tick.valid;
        push_rec.sck_level = (phase_reg == PH_HIGH);
        push_rec.tare_done = (tare_reads_done_next == READS_W'(TARE_READS));
        push_rec.net_valid = net_valid_now;
        push_rec.net_value = net_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
            half_period_reg     <= HALF_PERIOD_RST;
            gain_pulses_reg     <= GAIN_PULSES_RST;
        end
        else
        begin
            sample_interval_reg <= sample_interval_next;
            half_period_reg     <= half_period_next;
            gain_pulses_reg     <= gain_pulses_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_WAIT;
            pulse_index_reg      <= '0;
            half_counter_reg     <= '0;
            shift_word_reg       <= '0;
            interval_counter_reg <= '0;
            tare_sum_reg         <= '0;
            tare_reads_done_reg  <= '0;
            tare_value_reg       <= '0;
            net_reg              <= '0;
        end
        else
        begin
            tare_value_reg <= tare_value_next;
            if (accept)
            begin
                phase_reg            <= phase_next;
                pulse_index_reg      <= pulse_index_next;
                half_counter_reg     <= half_counter_next;
                shift_word_reg       <= shift_word_next;
                interval_counter_reg <= interval_counter_next;
                tare_sum_reg         <= tare_sum_next;
                tare_reads_done_reg  <= tare_reads_done_next;
                net_reg              <= net_next;
            end
        end
    end

    `LCAR_ASSERT_NOW(a_idle_only_after_tare, clk, rst_n, accept && phase_reg == PH_IDLE, was_tared)
    `LCAR_ASSERT_NEXT(a_net_then_idle, clk, rst_n, accept && push_rec.net_valid, phase_reg == PH_IDLE)
    `LCAR_ASSERT_NEXT(a_start_pulse, clk, rst_n, accept && phase_reg == PH_WAIT && !tick.dout_level, phase_reg == PH_HIGH && pulse_index_reg == '0)

endmodule

>>> rtl/lcar_digits.sv
// Back end: five-stage decimal split of the net value, last stage is the output register.
module lcar_digits import lcar_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  lcar_rec_t     head_rec,
    output logic          pop,
    lcar_result_if.source result
);

    localparam int LAST = NUM_DIGITS - 1;

    typedef struct packed {
        lcar_rec_t                      rec;
        logic [READING_W-1:0]           quot;
        lcar_digit_t [NUM_DIGITS-1:0]   digits;
    } stage_t;

    typedef struct packed {
        logic [READING_W-1:0] quot;
        lcar_digit_t          rem;
    } div10_t;

    function automatic div10_t div10(input logic [READING_W-1:0] v);
        logic [DIV10_PROD_W-1:0] prod;
        logic [READING_W-1:0]    q;
        logic [READING_W-1:0]    r;
        div10_t                  res;
        prod     = DIV10_PROD_W'(v) * DIV10_PROD_W'(DIV10_RECIP);
        q        = prod[DIV10_SHIFT +: READING_W];
        r        = v - (q << 3) - (q << 1);
        res.quot = q;
        res.rem  = r[DIGIT_W-1:0];
        return res;
    endfunction

    logic   stage_vld_reg [NUM_DIGITS];
    logic   stage_vld_next [NUM_DIGITS];
    stage_t stage_reg [NUM_DIGITS];
    stage_t stage_next [NUM_DIGITS];
    div10_t dv [NUM_DIGITS];
    logic   advance;

    // whole pipe moves when the output slot is free or being taken
    assign advance = !stage_vld_reg[LAST] || result.ready;
    assign pop     = advance && head_valid;

    always_comb
    begin
        dv[0]                = div10(head_rec.net_value);
        stage_vld_next[0]    = head_valid;
        stage_next[0].rec    = head_rec;
        stage_next[0].quot   = dv[0].quot;
        stage_next[0].digits = '0;
        stage_next[0].digits[0] = dv[0].rem;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            dv[i]                   = div10(stage_reg[i-1].quot);
            stage_vld_next[i]       = stage_vld_reg[i-1];
            stage_next[i]           = stage_reg[i-1];
            stage_next[i].quot      = dv[i].quot;
            stage_next[i].digits[i] = dv[i].rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                stage_vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                stage_vld_reg[i] <= stage_vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign result.valid              = stage_vld_reg[LAST];
    assign result.sck_level          = stage_reg[LAST].rec.sck_level;
    assign result.tare_done          = stage_reg[LAST].rec.tare_done;
    assign result.net_valid          = stage_reg[LAST].rec.net_valid;
    assign result.net_value          = stage_reg[LAST].rec.net_value;
    assign result.digit_units        = stage_reg[LAST].digits[0];
    assign result.digit_tens         = stage_reg[LAST].digits[1];
    assign result.digit_hundreds     = stage_reg[LAST].digits[2];
    assign result.digit_thousands    = stage_reg[LAST].digits[3];
    assign result.digit_tenthousands = stage_reg[LAST].digits[4];

endmodule

>>> rtl/load_cell_adc_reader_with_tare.sv
// Top level of the load-cell converter reader with tare.
//
//  channel   dir   handshake            payload
//  tick      in    valid/ready          dout_level
//  result    out   valid/ready          sck_level, tare_done, net_valid, net_value,
//                                       digit_units .. digit_tenthousands
//  cfg       in    cfg_we (no stall)    cfg_index, cfg_data
//
// One tick transaction per cycle while tick.ready is high, one result transaction per tick.
// A tick passes through the queue, then through the digit pipe stages to the result
// (one divide-by-ten multiplier per stage sets the depth).
// rst_n is asynchronous; no clearing pass, the block takes ticks right after reset.
// result.ready low with a result waiting freezes the digit pipe; the four-entry queue soaks up ticks until
// it fills, then tick.ready drops and the sequencer holds its state.
module load_cell_adc_reader_with_tare import lcar_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    lcar_tick_if.sink              tick,
    lcar_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // front end -> queue
    logic      push_valid;
    logic      push_ready;
    lcar_rec_t push_rec;

    // queue -> digit pipe
    logic      head_valid;
    logic      pop;
    lcar_rec_t head_rec;

    // Front end: runs the serial clock sequencer one tick per transaction,
    // accumulates the tare and forms the net value for the tick.
    lcar_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready)
    );

    // Queue: decouples the sequencer from output back-pressure.
    lcar_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Back end: decimal digits, one per stage; the last stage is the output register.
    lcar_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .result     (result)
    );

endmodule

>>> sim/load_cell_adc_reader_with_tare_tb.sv
`timescale 1ns / 1ps
// Testbench for the load-cell converter reader: converter emulation, tick predictor, scoreboard.
module load_cell_adc_reader_with_tare_tb;
    import lcar_pkg::*;

    // Receiver hold-off long enough to fill the input queue and the digit pipe.
    localparam int LONG_HOLD      = 120;
    // Idle cycles after the last result before a register write or the end.
    localparam int SETTLE_CYC     = 8;
    localparam int TICKS_PER_SET  = 30;
    localparam int RANDOM_SETS    = 4;
    localparam int RESET_TICKS    = 24;
    localparam int PARKED_TICKS   = 30;
    localparam int DRAIN_LIMIT    = 20000;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_kind_t;

    // One expected result transaction.
    typedef struct packed {
        logic                          sck;
        logic                          tared;
        logic                          fresh;
        logic [READING_W-1:0]          net;
        logic [NUM_DIGITS*DIGIT_W-1:0] digits;
    } tick_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lcar_tick_if   tick_if ();
    lcar_result_if res_if ();

    load_cell_adc_reader_with_tare dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: register copies and the sequencer as it stands
    // after every accepted tick transaction.
    // ------------------------------------------------------------------
    logic [INTERVAL_W-1:0]         interval_cfg = SAMPLE_INTERVAL_RST;
    logic [HALF_W-1:0]             half_cfg     = HALF_PERIOD_RST;
    logic [PULSE_W-1:0]            pulses_cfg   = GAIN_PULSES_RST;

    lcar_phase_t                   conv_phase   = PH_WAIT;
    logic [PULSE_W-1:0]            pulse_no     = '0;
    logic [HALF_W-1:0]             half_no      = '0;
    logic [SHIFT_W-1:0]            shift_bits   = '0;
    logic [INTERVAL_W-1:0]         interval_no  = '0;
    logic [TARE_SUM_W-1:0]         tare_acc     = '0;
    logic [READS_W-1:0]            tares_taken  = '0;
    logic [READING_W-1:0]          tare_level   = '0;
    logic [READING_W-1:0]          net_level    = '0;
    logic [NUM_DIGITS*DIGIT_W-1:0] digit_level  = '0;
    int                            readings_closed = 0;

    tick_result_t pending_results [$];

    // Converter emulation: words still to be sent, and the one on the wire.
    logic [RAW_W-1:0] conv_words [$];
    logic [RAW_W-1:0] cur_word   = '0;

    // Stimulus knobs, written by the test tasks only.
    bit          hold_start  = 1'b0;   // keep the data line high while waiting
    bit          gaps_on     = 1'b1;
    int          noise_pct   = 0;
    int          burst_left  = 0;
    stall_kind_t stall_mode  = STALL_RANDOM;
    int          holds_asked = 0;

    // Written by the receiver process only.
    int          holds_served = 0;

    int          mismatches = 0;

    string field_names [9] = '{"sck_level", "tare_done", "net_valid", "net_value",
                               "digit_units", "digit_tens", "digit_hundreds",
                               "digit_thousands", "digit_tenthousands"};

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Ends a reading. Tare readings feed the average; later ones give a net value.
    function automatic logic close_reading();
        logic [RAW_W-1:0]     raw;
        logic [RAW_W-1:0]     negated;
        logic [READING_W-1:0] reading;
        logic [READING_W-1:0] rest;
        readings_closed++;
        raw     = RAW_W'(shift_bits) << (RAW_W - DATA_BITS);
        negated = -raw;
        reading = negated[RAW_W-1 -: READING_W];
        if (tares_taken < TARE_READS)
        begin
            tare_acc    = tare_acc + reading;
            tares_taken = tares_taken + 1'b1;
            if (tares_taken >= TARE_READS)
            begin
                tare_level  = READING_W'(tare_acc / TARE_READS);
                conv_phase  = PH_IDLE;
                interval_no = '0;
            end
            else
            begin
                conv_phase = PH_WAIT;
            end
            return 1'b0;
        end
        net_level = reading - tare_level;
        rest      = net_level;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            digit_level[k*DIGIT_W +: DIGIT_W] = DIGIT_W'(rest % 10);
            rest = READING_W'(rest / 10);
        end
        conv_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // Advances the predicted sequencer by one tick and returns its result.
    function automatic tick_result_t predict_tick(logic dout);
        tick_result_t r;
        int unsigned  hp;
        int unsigned  iv;
        int unsigned  total;
        logic         trig;
        r     = '0;
        trig  = 1'b0;
        hp    = (half_cfg == 0) ? 1 : half_cfg;          // zero half period acts as one
        iv    = (interval_cfg == 0) ? 1 : interval_cfg;  // zero interval acts as one
        total = (pulses_cfg < MIN_PULSES) ? MIN_PULSES : pulses_cfg;
        r.sck = (conv_phase == PH_HIGH);

        // Interval timer runs freely once tared; a trigger while busy is lost.
        if (tares_taken >= TARE_READS)
        begin
            if (interval_no + 1 >= iv)
            begin
                interval_no = '0;
                trig        = 1'b1;
            end
            else
            begin
                interval_no = interval_no + 1'b1;
            end
        end

        case (conv_phase)
            PH_WAIT:
            begin
                if (!dout)
                begin
                    conv_phase = PH_HIGH;
                    pulse_no   = '0;
                    half_no    = '0;
                    shift_bits = '0;
                end
            end
            PH_HIGH:
            begin
                if (half_no + 1 >= hp)
                begin
                    half_no    = '0;
                    conv_phase = PH_LOW;
                end
                else
                begin
                    half_no = half_no + 1'b1;
                end
            end
            PH_LOW:
            begin
                // sample on the first low tick; gain pulses past the data bits sample nothing
                if (half_no == 0 && pulse_no < DATA_BITS)
                    shift_bits = {shift_bits[SHIFT_W-2:0], dout};
                if (half_no + 1 >= hp)
                begin
                    half_no  = '0;
                    pulse_no = pulse_no + 1'b1;
                    if (pulse_no >= total)
                    begin
                        pulse_no = '0;
                        r.fresh  = close_reading();
                    end
                    else
                    begin
                        conv_phase = PH_HIGH;
                    end
                end
                else
                begin
                    half_no = half_no + 1'b1;
                end
            end
            default:
            begin
                if (trig)
                    conv_phase = PH_WAIT;
            end
        endcase

        r.tared  = (tares_taken >= TARE_READS);
        r.net    = net_level;
        r.digits = digit_level;
        return r;
    endfunction

    // Plays the converter: data ready after a short random wait, then the
    // word MSB first at each sample point. Noise replaces the line at random.
    function automatic logic pick_dout();
        if (conv_phase == PH_WAIT && hold_start)
            return 1'b1;
        if ($urandom_range(99) < noise_pct)
            return 1'($urandom_range(1));
        case (conv_phase)
            PH_WAIT:
            begin
                if ($urandom_range(2) == 0)
                    return 1'b1;
                if (conv_words.size() != 0)
                    cur_word = conv_words.pop_front();
                else
                begin
                    case ($urandom_range(9))
                        0:       cur_word = '0;
                        1:       cur_word = '1;
                        2:       cur_word = 24'h800000;
                        3:       cur_word = 24'h7FFFFF;
                        default: cur_word = RAW_W'($urandom);
                    endcase
                end
                return 1'b0;
            end
            PH_LOW:
            begin
                if (half_no == 0 && pulse_no < DATA_BITS)
                    return cur_word[DATA_BITS - 1 - pulse_no];
            end
            default: ;
        endcase
        return 1'($urandom_range(1));
    endfunction

    // Offers one tick transaction, with bursts and gaps, and predicts it on acceptance.
    task automatic offer_tick();
        logic d;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                tick_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        d = pick_dout();
        tick_if.valid      <= 1'b1;
        tick_if.dout_level <= d;
        do
            @(posedge clk);
        while (!tick_if.ready);
        pending_results.push_back(predict_tick(d));
    endtask

    task automatic run_ticks(int count);
        hold_start = 1'b0;
        repeat (count) offer_tick();
    endtask

    task automatic run_readings(int count);
        int target;
        target     = readings_closed + count;
        hold_start = 1'b0;
        while (readings_closed < target)
            offer_tick();
    endtask

    // Sender pauses until every result is back, then lets the pipe go quiet.
    task automatic drain_results();
        tick_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Finish any reading in flight, park the sequencer, then drain.
    task automatic settle();
        hold_start = 1'b1;
        while (!(conv_phase == PH_IDLE || conv_phase == PH_WAIT))
            offer_tick();
        drain_results();
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SAMPLE_INTERVAL: interval_cfg = value[INTERVAL_W-1:0];
            CFG_HALF_PERIOD:     half_cfg     = value[HALF_W-1:0];
            CFG_GAIN_PULSES:     pulses_cfg   = value[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First pulses with register reset values (20-tick pulses), then the tare
    // at one-tick half periods. Words hit the all-ones reading, zero, the wrap
    // of all-ones raw and mid scale.
    task automatic test_reset_tare();
        conv_words = '{24'h000001, 24'h000000, 24'hFFFFFF, 24'h800000, 24'h5A5A5A};
        stall_mode = STALL_RANDOM;
        gaps_on    = 1'b1;
        run_ticks(RESET_TICKS);
        drain_results();
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(1));
        run_readings(TARE_READS);
        settle();
    endtask

    // Net values at the corners: zero, wrap to 65535, digit nines, a power of ten.
    task automatic test_net_corners();
        logic [READING_W-1:0] nets [$] = '{16'd0, 16'hFFFF, 16'd59999, 16'd10000};
        logic [RAW_W-1:0]     v;
        int                   count;
        write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(1));
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(1));
        // raw word whose negation has the wanted reading in its top bits
        foreach (nets[i])
        begin
            v = {READING_W'(nets[i] + tare_level), 8'($urandom_range(255))};
            conv_words.push_back(-v);
        end
        count = conv_words.size();
        stall_mode = STALL_PATTERN;
        run_readings(count);
        settle();
    endtask

    // The largest count (extra pulses past the data bits) and a count too small
    // for the data bits.
    task automatic test_gain_pulses();
        logic [PULSE_W-1:0] counts [$] = '{5'd31, 5'd0};
        stall_mode = STALL_RANDOM;
        foreach (counts[i])
        begin
            write_reg(CFG_GAIN_PULSES, CFG_DATA_W'(counts[i]));
            run_readings(1);
            settle();
        end
        write_reg(CFG_GAIN_PULSES, CFG_DATA_W'(GAIN_PULSES_RST));
    endtask

    // Zero half period acts as one.
    task automatic test_half_period();
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(0));
        run_readings(1);
        settle();
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(1));
    endtask

    // Zero interval, an interval too long to expire, and one shorter than a
    // reading so that triggers land while busy and are dropped.
    task automatic test_interval();
        write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(0));
        run_readings(1);
        settle();
        write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(24'hFFFFFF));
        run_ticks(PARKED_TICKS);
        settle();
        write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(20));
        run_readings(2);
        settle();
    endtask

    // Random register sets; mostly clean conversions with random words, some line noise.
    // First set runs with no idling on either side; one set holds the receiver off.
    task automatic test_random();
        for (int p = 0; p < RANDOM_SETS; p++)
        begin
            settle();
            write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'($urandom_range(1, 150)));
            write_reg(CFG_HALF_PERIOD, CFG_DATA_W'($urandom_range(1, 2)));
            write_reg(CFG_GAIN_PULSES, CFG_DATA_W'($urandom_range(20, 31)));
            noise_pct  = (p % 3 == 2) ? 10 : 0;
            gaps_on    = (p != 0);
            stall_mode = (p == 0) ? STALL_NONE : stall_kind_t'($urandom_range(1, 2));
            if (p == 2)
                holds_asked++;
            run_ticks(TICKS_PER_SET);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern; long hold-off counted here.
    // ------------------------------------------------------------------
    initial
    begin : result_stalls
        int hold_left;
        int cyc;
        hold_left    = 0;
        cyc          = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:   res_if.ready <= 1'b1;
                    STALL_RANDOM: res_if.ready <= ($urandom_range(3) != 0);
                    default:      res_if.ready <= ((cyc % 11) > 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: each result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        tick_result_t         want;
        logic [READING_W-1:0] got_f  [9];
        logic [READING_W-1:0] want_f [9];
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with no tick pending, net_value %0d",
                                          res_if.net_value));
            end
            else
            begin
                want   = pending_results.pop_front();
                got_f  = '{res_if.sck_level, res_if.tare_done, res_if.net_valid,
                           res_if.net_value, res_if.digit_units, res_if.digit_tens,
                           res_if.digit_hundreds, res_if.digit_thousands,
                           res_if.digit_tenthousands};
                want_f = '{want.sck, want.tared, want.fresh, want.net,
                           want.digits[3:0], want.digits[7:4], want.digits[11:8],
                           want.digits[15:12], want.digits[19:16]};
                for (int i = 0; i < 9; i++)
                begin
                    if (got_f[i] !== want_f[i])
                        report_mismatch($sformatf("%s got %0d expected %0d",
                                                  field_names[i], got_f[i], want_f[i]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int wait_cyc;
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SAMPLE_INTERVAL;
        cfg_data           = '0;
        tick_if.valid      = 1'b0;
        tick_if.dout_level = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_tare();
        test_net_corners();
        test_gain_pulses();
        test_half_period();
        test_interval();
        test_random();

        // all stimulus accepted: wait for the remaining results, bounded
        tick_if.valid <= 1'b0;
        for (wait_cyc = 0; wait_cyc < DRAIN_LIMIT && pending_results.size() != 0; wait_cyc++)
            @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run under the longest stalls.
    initial
    begin : watchdog
        #500_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
